// File: src/assert_macros.svh
// Assertion helpers used by the top RTL file of the fill engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define CSFE_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define CSFE_ASSERT_ALL(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

// File: src/csfe_pkg.sv
// ----------------------------------------------------------------------------
// csfe_pkg
// Shared constants, types and command codes of the clipped shape fill engine.
// ----------------------------------------------------------------------------
`default_nettype none

package csfe_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int XW    = 9;   // active_width register and x counter width
  localparam int YW    = 7;   // active_height register and y counter width
  localparam int CW    = 16;  // coordinate and size field width
  localparam int BW    = 18;  // signed width of the unclipped bounds
  localparam int CNT_W = 15;  // pixel count width
  localparam int PIX_W = 8;   // pixel width
  localparam int MODE_W = 3;

  localparam logic [XW-1:0] ACTIVE_WIDTH_RST  = XW'(256);
  localparam logic [YW-1:0] ACTIVE_HEIGHT_RST = YW'(64);

  localparam logic [MODE_W-1:0] MODE_RECT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HLINE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VLINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POINT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BOUND,
    ST_CLIP,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic bound;
    logic clip;
    logic step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic empty;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// File: src/clipped_shape_fill_engine.sv
// ----------------------------------------------------------------------------
// clipped_shape_fill_engine
// Frame store with clipped rectangle, line, point and read-pixel commands.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  mode, origin, sizes, color, fill
//   out      output     out_valid/out_stall  read_value, pixels_written
//   cfg      input      APB, pready high     active_width, active_height
//
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT pixels,
// one per cycle, with the input stalled. A command is loaded, bounded and
// clipped, then steps through its clipped bounding box, unless that box is
// empty, writing through the single write port of the frame store.
// Outlines walk their whole clipped box. The next item is taken while a
// result still waits; a result is only finished once the output is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module clipped_shape_fill_engine #(
  parameter int MAX_WIDTH  = csfe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = csfe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [csfe_pkg::MODE_W-1:0]     in_mode,
  input  logic signed [csfe_pkg::CW-1:0]  in_pos_x,
  input  logic signed [csfe_pkg::CW-1:0]  in_pos_y,
  input  logic signed [csfe_pkg::CW-1:0]  in_size_w,
  input  logic signed [csfe_pkg::CW-1:0]  in_size_h,
  input  logic [csfe_pkg::PIX_W-1:0]      in_pixel_color,
  input  logic                            in_fill_inside,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [csfe_pkg::PIX_W-1:0]      out_read_value,
  output logic [csfe_pkg::CNT_W-1:0]      out_pixels_written,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [2:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import csfe_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [XW-1:0]    active_width_r;
  logic [YW-1:0]    active_height_r;
  logic             cfg_write;
  cmd_t             cmd;
  status_t          status;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= ACTIVE_WIDTH_RST;
      active_height_r <= ACTIVE_HEIGHT_RST;
    end else if (cfg_write) begin
      if (cfg_paddr[2] == REG_WIDTH) begin
        active_width_r <= cfg_pwdata[XW-1:0];
      end else begin
        active_height_r <= cfg_pwdata[YW-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {{(32-YW){1'b0}}, active_height_r}
                                                   : {{(32-XW){1'b0}}, active_width_r};

  csfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  csfe_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .active_width       (active_width_r),
    .active_height      (active_height_r),
    .in_mode            (in_mode),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_size_w          (in_size_w),
    .in_size_h          (in_size_h),
    .in_pixel_color     (in_pixel_color),
    .in_fill_inside     (in_fill_inside),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_read_value     (out_read_value),
    .out_pixels_written (out_pixels_written)
  );

  csfe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The clearing pass starts at reset and blocks the input until it ends.
  `CSFE_ASSERT_ALL(a_reset_starts_clear, clk, !rst_n |=> (in_stall && !out_valid), "reset must start the clearing pass")
  `CSFE_ASSERT(a_clear_blocks_input, clk, rst_n, cmd.clr_step |-> in_stall, "item taken during clearing pass")
  `CSFE_ASSERT(a_accept_then_busy, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "second item taken while busy")
  `CSFE_ASSERT(a_capture_free_slot, clk, rst_n, cmd.capture |-> (!out_valid || !out_stall), "result overwrote a waiting item")

endmodule

`default_nettype wire

// File: src/csfe_ram.sv
// ----------------------------------------------------------------------------
// csfe_ram
// Generic RAM with one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module csfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/csfe_ctrl.sv
// ----------------------------------------------------------------------------
// csfe_ctrl
// Controller of the fill engine: clearing pass, command sequencing and the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module csfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  csfe_pkg::status_t  status,
  output csfe_pkg::cmd_t     cmd
);
  import csfe_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        cmd.bound = 1'b1;
        state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        cmd.clip  = 1'b1;
        state_nxt = status.empty ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: src/csfe_datapath.sv
// ----------------------------------------------------------------------------
// csfe_datapath
// Datapath of the fill engine: bounds and clipping, the pixel walk with its
// address multiplier, pixel count, clearing counter and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module csfe_datapath #(
  parameter int MAX_WIDTH  = csfe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = csfe_pkg::MAX_HEIGHT_DEF,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csfe_pkg::cmd_t                      cmd,
  output csfe_pkg::status_t                   status,
  input  logic [csfe_pkg::XW-1:0]             active_width,
  input  logic [csfe_pkg::YW-1:0]             active_height,
  input  logic [csfe_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [csfe_pkg::CW-1:0]      in_pos_x,
  input  logic signed [csfe_pkg::CW-1:0]      in_pos_y,
  input  logic signed [csfe_pkg::CW-1:0]      in_size_w,
  input  logic signed [csfe_pkg::CW-1:0]      in_size_h,
  input  logic [csfe_pkg::PIX_W-1:0]          in_pixel_color,
  input  logic                                in_fill_inside,
  output logic                                ram_we,
  output logic [AW-1:0]                       ram_waddr,
  output logic [csfe_pkg::PIX_W-1:0]          ram_wdata,
  output logic [AW-1:0]                       ram_raddr,
  input  logic [csfe_pkg::PIX_W-1:0]          ram_rdata,
  output logic [csfe_pkg::PIX_W-1:0]          out_read_value,
  output logic [csfe_pkg::CNT_W-1:0]          out_pixels_written
);
  import csfe_pkg::*;

  localparam int WCAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int HCAP  = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
  localparam int LIN_W = XW + YW + 1;
  localparam logic signed [BW-1:0] ONE_S  = BW'(1);
  localparam logic signed [BW-1:0] ZERO_S = '0;

  logic [MODE_W-1:0]     mode_r;
  logic signed [CW-1:0]  pos_x_r, pos_y_r, size_w_r, size_h_r;
  logic [PIX_W-1:0]      color_r;
  logic                  fill_r;
  logic signed [BW-1:0]  sx0_r, sx1_r, sy0_r, sy1_r;
  logic [XW-1:0]         xa_r, xb_r, cx_r;
  logic [YW-1:0]         yb_r, cy_r;
  logic                  empty_r;
  logic [CNT_W-1:0]      count_r;
  logic [AW-1:0]         pix_addr_r;
  logic                  pix_we_r;
  logic [AW-1:0]         clr_cnt_r;
  logic [PIX_W-1:0]      read_value_r;
  logic [CNT_W-1:0]      pixels_written_r;

  logic [XW-1:0]         eff_w;
  logic [YW-1:0]         eff_h;
  logic signed [BW-1:0]  px_e, py_e, sw_e, sh_e;
  logic signed [BW-1:0]  sx1_nxt, sy1_nxt;
  logic signed [BW-1:0]  w_lim, h_lim, xa_s, xb_s, ya_s, yb_s;
  logic signed [BW-1:0]  cx_s, cy_s;
  logic                  mode_ok, write_mode, solid, on_edge, do_write;
  logic [LIN_W-1:0]      prod, lin;

  assign eff_w = (active_width > XW'(WCAP)) ? XW'(WCAP) : active_width;
  assign eff_h = (active_height > YW'(HCAP)) ? YW'(HCAP) : active_height;

  assign px_e = {{(BW-CW){pos_x_r[CW-1]}}, pos_x_r};
  assign py_e = {{(BW-CW){pos_y_r[CW-1]}}, pos_y_r};
  assign sw_e = {{(BW-CW){size_w_r[CW-1]}}, size_w_r};
  assign sh_e = {{(BW-CW){size_h_r[CW-1]}}, size_h_r};

  always_comb begin
    case (mode_r)
      MODE_RECT: begin
        sx1_nxt = px_e + sw_e - ONE_S;
        sy1_nxt = py_e + sh_e - ONE_S;
      end
      MODE_HLINE: begin
        sx1_nxt = px_e + sw_e - ONE_S;
        sy1_nxt = py_e;
      end
      MODE_VLINE: begin
        sx1_nxt = px_e;
        sy1_nxt = py_e + sw_e - ONE_S;
      end
      default: begin
        sx1_nxt = px_e;
        sy1_nxt = py_e;
      end
    endcase
  end

  assign w_lim = $signed({{(BW-XW){1'b0}}, eff_w}) - ONE_S;
  assign h_lim = $signed({{(BW-YW){1'b0}}, eff_h}) - ONE_S;
  assign xa_s  = (sx0_r < ZERO_S) ? ZERO_S : sx0_r;
  assign xb_s  = (sx1_r > w_lim) ? w_lim : sx1_r;
  assign ya_s  = (sy0_r < ZERO_S) ? ZERO_S : sy0_r;
  assign yb_s  = (sy1_r > h_lim) ? h_lim : sy1_r;

  assign mode_ok    = (mode_r <= MODE_READ);
  assign write_mode = mode_r inside {MODE_RECT, MODE_HLINE, MODE_VLINE, MODE_POINT};
  assign solid      = (mode_r != MODE_RECT) || fill_r;

  assign cx_s    = $signed({{(BW-XW){1'b0}}, cx_r});
  assign cy_s    = $signed({{(BW-YW){1'b0}}, cy_r});
  assign on_edge = (cx_s == sx0_r) || (cx_s == sx1_r) || (cy_s == sy0_r) || (cy_s == sy1_r);
  assign do_write = write_mode && (solid || on_edge);

  assign prod = LIN_W'(cy_r) * LIN_W'(eff_w);
  assign lin  = prod + LIN_W'(cx_r);

  assign status.clr_done = (clr_cnt_r == AW'(DEPTH - 1));
  assign status.empty    = !mode_ok || (xa_s > xb_s) || (ya_s > yb_s);
  assign status.last     = (cx_r == xb_r) && (cy_r == yb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      pix_we_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      pix_we_r <= cmd.step && do_write;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      pos_x_r  <= in_pos_x;
      pos_y_r  <= in_pos_y;
      size_w_r <= in_size_w;
      size_h_r <= in_size_h;
      color_r  <= in_pixel_color;
      fill_r   <= in_fill_inside;
      count_r  <= '0;
    end
    if (cmd.bound) begin
      sx0_r <= px_e;
      sy0_r <= py_e;
      sx1_r <= sx1_nxt;
      sy1_r <= sy1_nxt;
    end
    if (cmd.clip) begin
      xa_r    <= xa_s[XW-1:0];
      xb_r    <= xb_s[XW-1:0];
      yb_r    <= yb_s[YW-1:0];
      cx_r    <= xa_s[XW-1:0];
      cy_r    <= ya_s[YW-1:0];
      empty_r <= status.empty;
    end
    if (cmd.step) begin
      pix_addr_r <= AW'(lin);
      if (cx_r == xb_r) begin
        cx_r <= xa_r;
        cy_r <= cy_r + YW'(1);
      end else begin
        cx_r <= cx_r + XW'(1);
      end
      if (do_write && (count_r != '1)) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
    if (cmd.capture) begin
      read_value_r     <= ((mode_r == MODE_READ) && !empty_r) ? ram_rdata : '0;
      pixels_written_r <= count_r;
    end
  end

  assign ram_we    = cmd.clr_step || pix_we_r;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : pix_addr_r;
  assign ram_wdata = cmd.clr_step ? '0 : color_r;
  assign ram_raddr = pix_addr_r;

  assign out_read_value     = read_value_r;
  assign out_pixels_written = pixels_written_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clipped shape fill engine. A directed table of
// drawing and read-pixel items comes first, then random phases under several
// active sizes written over APB. Typed rows give their result; a software
// frame store copy predicts the rest, checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import csfe_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam int STORE_PIXELS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int COUNT_SAT = 32767;
  localparam int NUM_ROWS = 27;
  localparam int NUM_PHASES = 9;
  localparam int RAND_NARROW = -1;
  localparam int RAND_WIDE = -2;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] size_w;
    logic signed [CW-1:0] size_h;
    logic [PIX_W-1:0]     color;
    logic                 fill;
  } stroke_t;

  typedef struct packed {
    logic [PIX_W-1:0] rd;
    logic [CNT_W-1:0] cnt;
  } stroke_res_t;

  typedef struct packed {
    stroke_t     cmd;
    logic        typed;
    stroke_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic signed [CW-1:0] in_pos_x = '0;
  logic signed [CW-1:0] in_pos_y = '0;
  logic signed [CW-1:0] in_size_w = '0;
  logic signed [CW-1:0] in_size_h = '0;
  logic [PIX_W-1:0] in_pixel_color = '0;
  logic in_fill_inside = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] out_read_value;
  logic [CNT_W-1:0] out_pixels_written;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  clipped_shape_fill_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_size_w(in_size_w), .in_size_h(in_size_h),
    .in_pixel_color(in_pixel_color), .in_fill_inside(in_fill_inside),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_value(out_read_value), .out_pixels_written(out_pixels_written),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  logic [PIX_W-1:0] canvas [STORE_PIXELS];
  logic [XW-1:0] canvas_w;
  logic [YW-1:0] canvas_h;
  stroke_res_t pending [$];
  stroke_res_t got_want;
  int err_count = 0;
  int in_gap_chance = 0;
  int out_stall_chance = 0;
  int stall_left = 0;
  int big_left = 40;

  dir_row_t dir_table [NUM_ROWS] = '{
    '{'{MODE_READ, 0, 0, 0, 0, 8'h00, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_READ, 255, 63, -1, -1, 8'hFF, 1'b1}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_RECT, 0, 0, 256, 64, 8'hFF, 1'b1}, 1'b1, '{8'h00, 15'd16384}},
    '{'{MODE_READ, 255, 63, 0, 0, 8'h00, 1'b0}, 1'b1, '{8'hFF, 15'd0}},
    '{'{MODE_READ, 0, 0, 0, 0, 8'h00, 1'b0}, 1'b1, '{8'hFF, 15'd0}},
    '{'{MODE_RECT, -32768, -32768, 32767, 32767, 8'h01, 1'b1}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_RECT, 32767, 32767, 32767, 32767, 8'h02, 1'b1}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_RECT, -1, -1, 258, 66, 8'h00, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_RECT, 0, 0, 256, 64, 8'h5A, 1'b0}, 1'b0, '{8'h00, 15'd0}},
    '{'{MODE_RECT, 10, 10, 0, 5, 8'h03, 1'b1}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_RECT, 10, 10, 5, -32768, 8'h03, 1'b1}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_RECT, 10, 10, -1, 4, 8'h03, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_RECT, 3, 5, 4, 3, 8'hC3, 1'b0}, 1'b0, '{8'h00, 15'd0}},
    '{'{MODE_HLINE, -10, 10, 30, -32768, 8'h11, 1'b1}, 1'b0, '{8'h00, 15'd0}},
    '{'{MODE_HLINE, 0, -1, 100, 0, 8'h04, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_VLINE, 255, 60, 32767, 0, 8'h33, 1'b0}, 1'b0, '{8'h00, 15'd0}},
    '{'{MODE_VLINE, 256, 0, 10, 0, 8'h04, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_VLINE, 5, 5, 0, 7, 8'h04, 1'b1}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_POINT, 255, 63, -32768, -32768, 8'h80, 1'b1}, 1'b1, '{8'h00, 15'd1}},
    '{'{MODE_POINT, -1, 0, 5, 5, 8'h04, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_READ, 255, 63, 32767, 32767, 8'h00, 1'b1}, 1'b1, '{8'h80, 15'd0}},
    '{'{MODE_READ, 256, 0, 0, 0, 8'h00, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_READ, 0, -32768, 0, 0, 8'h00, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_READ, 0, 0, 0, 0, 8'h00, 1'b0}, 1'b0, '{8'h00, 15'd0}},
    '{'{MODE_SPARE_5, 1, 1, 5, 5, 8'h07, 1'b1}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_SPARE_6, 2, 2, 5, 5, 8'h07, 1'b0}, 1'b1, '{8'h00, 15'd0}},
    '{'{MODE_SPARE_7, 3, 3, 5, 5, 8'h07, 1'b1}, 1'b1, '{8'h00, 15'd0}}
  };

  int ph_w [NUM_PHASES]     = '{256, 1, 0, 256, 511, RAND_NARROW, 17, RAND_WIDE, 256};
  int ph_h [NUM_PHASES]     = '{64, 1, 64, 0, 127, RAND_NARROW, 9, RAND_WIDE, 64};
  int ph_items [NUM_PHASES] = '{200, 150, 80, 80, 250, 250, 200, 250, 300};
  int ph_gap [NUM_PHASES]   = '{3, 6, 4, 4, 10, 3, 0, 5, 0};
  int ph_stall [NUM_PHASES] = '{4, 3, 5, 5, 8, 3, 0, 6, 0};

  function automatic stroke_res_t paint(stroke_t c);
    stroke_res_t r;
    int ew, eh, x0, y0, w, h, x1, y1, xa, xb, ya, yb, cnt;
    ew = (canvas_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(canvas_w);
    eh = (canvas_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(canvas_h);
    x0 = int'(c.pos_x);
    y0 = int'(c.pos_y);
    w = int'(c.size_w);
    h = int'(c.size_h);
    cnt = 0;
    r.rd = '0;
    xa = 0;
    xb = -1;
    ya = 0;
    yb = -1;
    x1 = x0 + w - 1;
    y1 = y0 + h - 1;
    case (c.mode)
      MODE_RECT: begin
        xa = (x0 < 0) ? 0 : x0;
        xb = (x1 > ew - 1) ? ew - 1 : x1;
        ya = (y0 < 0) ? 0 : y0;
        yb = (y1 > eh - 1) ? eh - 1 : y1;
      end
      MODE_HLINE: begin
        if (y0 >= 0 && y0 < eh) begin
          xa = (x0 < 0) ? 0 : x0;
          xb = (x1 > ew - 1) ? ew - 1 : x1;
          ya = y0;
          yb = y0;
        end
      end
      MODE_VLINE: begin
        // A vertical line takes its length from size_w.
        y1 = y0 + w - 1;
        if (x0 >= 0 && x0 < ew) begin
          xa = x0;
          xb = x0;
          ya = (y0 < 0) ? 0 : y0;
          yb = (y1 > eh - 1) ? eh - 1 : y1;
        end
      end
      MODE_POINT: begin
        if (x0 >= 0 && x0 < ew && y0 >= 0 && y0 < eh) begin
          xa = x0;
          xb = x0;
          ya = y0;
          yb = y0;
        end
      end
      MODE_READ: begin
        if (x0 >= 0 && x0 < ew && y0 >= 0 && y0 < eh) r.rd = canvas[y0 * ew + x0];
      end
      default: ;
    endcase
    for (int x = xa; x <= xb; x++) begin
      for (int y = ya; y <= yb; y++) begin
        if (c.mode != MODE_RECT || c.fill || x == x0 || x == x1 || y == y0 || y == y1) begin
          canvas[y * ew + x] = c.color;
          if (cnt < COUNT_SAT) cnt++;
        end
      end
    end
    r.cnt = cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int span);
    if ($urandom_range(0, 15) == 0) return CW'($urandom);
    return CW'(int'($urandom_range(0, span + 16)) - 8);
  endfunction

  function automatic logic signed [CW-1:0] pick_size();
    if (big_left > 0 && $urandom_range(0, 63) == 0) begin
      big_left--;
      return CW'($urandom);
    end
    return CW'(int'($urandom_range(0, 22)) - 2);
  endfunction

  function automatic stroke_t random_stroke();
    stroke_t c;
    int pick, ew, eh;
    ew = (canvas_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(canvas_w);
    eh = (canvas_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(canvas_h);
    pick = $urandom_range(0, 99);
    if (pick < 24) c.mode = MODE_RECT;
    else if (pick < 36) c.mode = MODE_HLINE;
    else if (pick < 48) c.mode = MODE_VLINE;
    else if (pick < 60) c.mode = MODE_POINT;
    else if (pick < 96) c.mode = MODE_READ;
    else if (pick < 97) c.mode = MODE_SPARE_5;
    else if (pick < 98) c.mode = MODE_SPARE_6;
    else c.mode = MODE_SPARE_7;
    c.pos_x = pick_coord(ew);
    c.pos_y = pick_coord(eh);
    c.size_w = pick_size();
    c.size_h = pick_size();
    c.color = PIX_W'($urandom);
    c.fill = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_stroke(input stroke_t c, input logic typed, input stroke_res_t want);
    int gap;
    stroke_res_t res;
    if (in_gap_chance != 0 && $urandom_range(0, in_gap_chance - 1) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_mode = c.mode;
    in_pos_x = c.pos_x;
    in_pos_y = c.pos_y;
    in_size_w = c.size_w;
    in_size_h = c.size_h;
    in_pixel_color = c.color;
    in_fill_inside = c.fill;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    res = paint(c);
    pending.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic reg_access(input logic idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = wr;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_canvas(input int w_val, input int h_val);
    logic [31:0] rdata;
    reg_access(REG_WIDTH, 1'b1, ($urandom & ~32'h1FF) | 32'(w_val), rdata);
    reg_access(REG_HEIGHT, 1'b1, ($urandom & ~32'h7F) | 32'(h_val), rdata);
    canvas_w = XW'(w_val);
    canvas_h = YW'(h_val);
    reg_access(REG_WIDTH, 1'b0, '0, rdata);
    if (rdata[XW-1:0] !== canvas_w) begin
      $display("%0t: active_width read back expected %0d actual %0d",
               $time, canvas_w, rdata[XW-1:0]);
      err_count++;
    end
    reg_access(REG_HEIGHT, 1'b0, '0, rdata);
    if (rdata[YW-1:0] !== canvas_h) begin
      $display("%0t: active_height read back expected %0d actual %0d",
               $time, canvas_h, rdata[YW-1:0]);
      err_count++;
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (out_stall_chance != 0 && $urandom_range(0, out_stall_chance - 1) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual read_value %0d pixels_written %0d",
                 $time, out_read_value, out_pixels_written);
        err_count++;
      end else begin
        got_want = pending.pop_front();
        if (out_read_value !== got_want.rd) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, got_want.rd, out_read_value);
          err_count++;
        end
        if (out_pixels_written !== got_want.cnt) begin
          $display("%0t: pixels_written expected %0d actual %0d",
                   $time, got_want.cnt, out_pixels_written);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(64'd100_000_000);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    stroke_t cmd;
    int w_val, h_val;
    for (int i = 0; i < STORE_PIXELS; i++) canvas[i] = '0;
    canvas_w = ACTIVE_WIDTH_RST;
    canvas_h = ACTIVE_HEIGHT_RST;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    in_gap_chance = 4;
    out_stall_chance = 5;
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_stroke(dir_table[i].cmd, dir_table[i].typed, dir_table[i].res);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (ph_w[p] == RAND_NARROW) begin
        w_val = $urandom_range(1, 256);
        h_val = $urandom_range(1, 64);
      end else if (ph_w[p] == RAND_WIDE) begin
        w_val = $urandom_range(0, 511);
        h_val = $urandom_range(0, 127);
      end else begin
        w_val = ph_w[p];
        h_val = ph_h[p];
      end
      set_canvas(w_val, h_val);
      in_gap_chance = ph_gap[p];
      out_stall_chance = ph_stall[p];
      for (int n = 0; n < ph_items[p]; n++) begin
        cmd = random_stroke();
        send_stroke(cmd, 1'b0, '0);
      end
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
